@@ sv/resource_lock_table_with_generations_defines.svh @@
// assertion macros for the resource lock table
// used by rltg_ctrl and rltg_dp, expects clk and arst_n in scope
`ifndef RESOURCE_LOCK_TABLE_WITH_GENERATIONS_DEFINES_SVH
`define RESOURCE_LOCK_TABLE_WITH_GENERATIONS_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define RLTG_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define RLTG_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define RLTG_ASSERT(lbl, prop, msg)
`define RLTG_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

@@ sv/rltg_pkg.sv @@
// shared types, mode codes and defaults for the resource lock table
// no dependencies
package rltg_pkg;

	localparam int NUM_SLOTS_DEF  = 8;
	localparam int MAINT_SLOT_DEF = 7;
	localparam int ACTOR_MAX_DEF  = 3;

	localparam int MODE_W  = 3;
	localparam int RES_W   = 4;
	localparam int ACTOR_W = 3;
	localparam int TIME_W  = 32;
	localparam int GEN_W   = 32;
	localparam int TOT_W   = 4;
	localparam int IN_DATA_W  = 72;
	localparam int OUT_DATA_W = 80;

	localparam logic [MODE_W-1:0] MODE_BEGIN      = 3'd0;
	localparam logic [MODE_W-1:0] MODE_REQ_CANCEL = 3'd1;
	localparam logic [MODE_W-1:0] MODE_QRY_CANCEL = 3'd2;
	localparam logic [MODE_W-1:0] MODE_FINISH     = 3'd3;
	localparam logic [MODE_W-1:0] MODE_MANUAL_OK  = 3'd4;
	localparam logic [MODE_W-1:0] MODE_READ       = 3'd5;

	typedef struct packed {
		logic [MODE_W-1:0]  mode;
		logic [RES_W-1:0]   resource;
		logic [ACTOR_W-1:0] actor;
		logic               cancellable;
		logic [TIME_W-1:0]  start_time_ms;
		logic [GEN_W-1:0]   generation;
	} item_t;

	typedef struct packed {
		logic               ok;
		logic [GEN_W-1:0]   out_generation;
		logic               slot_is_active;
		logic               slot_is_cancellable;
		logic               slot_cancel_flag;
		logic [TIME_W-1:0]  slot_start_ms;
		logic [ACTOR_W-1:0] slot_actor;
		logic [TOT_W-1:0]   active_total;
	} result_t;

	typedef struct packed {
		logic load;
		logic exec;
	} cmd_t;

endpackage

@@ sv/rltg_ctrl.sv @@
// controller: input capture, execute step and output register handshake
// depends on rltg_pkg and the defines header
`include "resource_lock_table_with_generations_defines.svh"
module rltg_ctrl
	import rltg_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	output logic m_tvalid,
	input  logic m_tready,
	output cmd_t cmd
);

	localparam logic [0:0] ST_IDLE = 1'b0;
	localparam logic [0:0] ST_EXEC = 1'b1;

	logic [0:0] state_q;
	logic       out_valid_q;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign cmd.load = s_tvalid && s_tready;
	assign cmd.exec = (state_q == ST_EXEC) && (!out_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.load) state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					if (cmd.exec) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
			if (cmd.exec) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	`RLTG_ASSERT(a_load_to_exec, cmd.load |=> (state_q == ST_EXEC), "load did not enter exec")
	`RLTG_ASSERT(a_exec_shows_word, cmd.exec |=> m_tvalid, "executed word not presented")
	`RLTG_ASSERT(a_no_overwrite, cmd.exec |-> (!out_valid_q || m_tready), "result overwritten")
	`RLTG_ASSERT_ALWAYS(a_load_excl, !(cmd.load && cmd.exec), "load and exec together")

endmodule

@@ sv/rltg_dp.sv @@
// datapath: slot table, active counter, input and result registers
// depends on rltg_pkg and the defines header
`include "resource_lock_table_with_generations_defines.svh"
module rltg_dp
	import rltg_pkg::*;
#(
	parameter int NUM_SLOTS  = NUM_SLOTS_DEF,
	parameter int MAINT_SLOT = MAINT_SLOT_DEF,
	parameter int ACTOR_MAX  = ACTOR_MAX_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  cmd_t    cmd,
	input  item_t   in_item,
	output result_t result
);

	localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int CW = $clog2(NUM_SLOTS + 1);
	localparam bit MAINT_EN = (MAINT_SLOT < NUM_SLOTS);
	localparam int MI = MAINT_EN ? MAINT_SLOT : 0;

	item_t   item_q;
	result_t res_q;
	result_t res_d;

	logic [NUM_SLOTS-1:0] act_q;
	logic [NUM_SLOTS-1:0] canc_q;
	logic [NUM_SLOTS-1:0] cflag_q;
	logic [GEN_W-1:0]     gen_q   [NUM_SLOTS];
	logic [TIME_W-1:0]    start_q [NUM_SLOTS];
	logic [ACTOR_W-1:0]   actor_q [NUM_SLOTS];
	logic [CW-1:0]        cnt_q;

	logic [IW-1:0]    idx;
	logic             valid;
	logic             is_maint;
	logic             maint_act;
	logic             actor_ok;
	logic             gen_match;
	logic             gen_nz;
	logic [GEN_W-1:0] ng;
	logic             do_begin;
	logic             do_cancel;
	logic             do_finish;
	logic [CW-1:0]    cnt_d;

	assign idx       = item_q.resource[IW-1:0];
	assign valid     = ({1'b0, item_q.resource} < (RES_W + 1)'(NUM_SLOTS));
	assign is_maint  = (item_q.resource == RES_W'(MAINT_SLOT));
	assign maint_act = MAINT_EN && act_q[MI];
	assign actor_ok  = (item_q.actor != '0) && (item_q.actor <= ACTOR_W'(ACTOR_MAX));
	assign gen_match = (gen_q[idx] == item_q.generation);
	assign gen_nz    = (item_q.generation != '0);

	always_comb begin
		ng = gen_q[idx] + GEN_W'(1);
		if (ng == '0) ng = GEN_W'(1);
	end

	always_comb begin
		res_d     = '0;
		do_begin  = 1'b0;
		do_cancel = 1'b0;
		do_finish = 1'b0;
		case (item_q.mode)
			MODE_BEGIN: begin
				if (valid && actor_ok && !(!is_maint && maint_act) &&
					!(is_maint && cnt_q != '0) && !act_q[idx]) begin
					do_begin             = 1'b1;
					res_d.ok             = 1'b1;
					res_d.out_generation = ng;
				end
			end
			MODE_REQ_CANCEL: begin
				if (valid && gen_nz && act_q[idx] && canc_q[idx] && gen_match) begin
					do_cancel = 1'b1;
					res_d.ok  = 1'b1;
				end
			end
			MODE_QRY_CANCEL: begin
				if (!valid || !gen_nz) res_d.ok = 1'b1;
				else res_d.ok = !act_q[idx] || !gen_match || cflag_q[idx];
			end
			MODE_FINISH: begin
				if (valid && gen_nz && act_q[idx] && gen_match) begin
					do_finish = 1'b1;
					res_d.ok  = 1'b1;
				end
			end
			MODE_MANUAL_OK: begin
				res_d.ok = valid && !act_q[idx] && (is_maint || !maint_act);
			end
			MODE_READ: begin
				if (valid) begin
					res_d.ok                  = 1'b1;
					res_d.out_generation      = gen_q[idx];
					res_d.slot_is_active      = act_q[idx];
					res_d.slot_is_cancellable = canc_q[idx];
					res_d.slot_cancel_flag    = cflag_q[idx];
					res_d.slot_start_ms       = start_q[idx];
					res_d.slot_actor          = actor_q[idx];
				end
			end
			default: res_d = '0;
		endcase
		cnt_d = cnt_q;
		if (do_begin) cnt_d = cnt_q + CW'(1);
		else if (do_finish) cnt_d = cnt_q - CW'(1);
		res_d.active_total = (cnt_d > CW'(15)) ? TOT_W'(15) : TOT_W'(cnt_d);
	end

	always_ff @(posedge clk) begin
		if (cmd.load) item_q <= in_item;
		if (cmd.exec) res_q <= res_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q   <= '0;
			canc_q  <= '0;
			cflag_q <= '0;
			cnt_q   <= '0;
			for (int i = 0; i < NUM_SLOTS; i++) begin
				gen_q[i]   <= '0;
				start_q[i] <= '0;
				actor_q[i] <= '0;
			end
		end else if (cmd.exec) begin
			cnt_q <= cnt_d;
			if (do_begin) begin
				act_q[idx]   <= 1'b1;
				canc_q[idx]  <= item_q.cancellable;
				cflag_q[idx] <= 1'b0;
				gen_q[idx]   <= ng;
				start_q[idx] <= item_q.start_time_ms;
				actor_q[idx] <= item_q.actor;
			end
			if (do_finish) begin
				act_q[idx]   <= 1'b0;
				canc_q[idx]  <= 1'b0;
				cflag_q[idx] <= 1'b0;
				start_q[idx] <= '0;
				actor_q[idx] <= '0;
			end
			if (do_cancel) cflag_q[idx] <= 1'b1;
		end
	end

	assign result = res_q;

	`RLTG_ASSERT(a_cnt_matches, cnt_q == CW'($countones(act_q)), "active count out of step")
	`RLTG_ASSERT(a_maint_alone, maint_act |-> (cnt_q == CW'(1)), "maintenance slot not alone")
	`RLTG_ASSERT(a_one_update, $onehot0({do_begin, do_cancel, do_finish}), "multiple slot updates")
	`RLTG_ASSERT(a_cflag_needs_act, (cflag_q & ~act_q) == '0, "cancel flag on idle slot")

endmodule

@@ sv/resource_lock_table_with_generations.sv @@
// top level of the resource lock table: stream ports, controller and datapath
// depends on rltg_pkg, rltg_ctrl and rltg_dp
//
// channel  dir  handshake          payload
// s        in   s_tvalid/s_tready  s_tuser mode, s_tdata operands
// m        out  m_tvalid/m_tready  m_tdata result word
//
// each word is first captured into the input register, then one
// read-modify-write of the addressed slot loads the result register
// the active total comes from a running counter, no sweep over the slots
// a new word is taken while the previous result waits in the output register
// a stalled output holds the execute step until the result register frees
// reset clears all slots and the counter at once, no clearing pass
module resource_lock_table_with_generations
	import rltg_pkg::*;
#(
	parameter int NUM_SLOTS  = NUM_SLOTS_DEF,
	parameter int MAINT_SLOT = MAINT_SLOT_DEF,
	parameter int ACTOR_MAX  = ACTOR_MAX_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// resource, actor, cancellable, start_time_ms, generation
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// mode
	input  logic [MODE_W-1:0]     s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// ok, out_generation, slot_is_active, slot_is_cancellable, slot_cancel_flag,
	// slot_start_ms, slot_actor, active_total, zero fill
	output logic [OUT_DATA_W-1:0] m_tdata
);

	cmd_t    cmd;
	item_t   in_item;
	result_t result;

	assign in_item.mode          = s_tuser;
	assign in_item.resource      = s_tdata[3:0];
	assign in_item.actor         = s_tdata[6:4];
	assign in_item.cancellable   = s_tdata[7];
	assign in_item.start_time_ms = s_tdata[39:8];
	assign in_item.generation    = s_tdata[71:40];

	assign m_tdata = {5'b0, result.active_total, result.slot_actor, result.slot_start_ms,
		result.slot_cancel_flag, result.slot_is_cancellable, result.slot_is_active,
		result.out_generation, result.ok};

	rltg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	rltg_dp #(
		.NUM_SLOTS  (NUM_SLOTS),
		.MAINT_SLOT (MAINT_SLOT),
		.ACTOR_MAX  (ACTOR_MAX)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.in_item (in_item),
		.result  (result)
	);

endmodule

@@ tb/sv/resource_lock_table_with_generations_tb.sv @@
// self-checking testbench for the resource lock table with generations
// drives stream words with random gaps and stalls, predicts every result word
// from its own copy of the slot table; depends on rltg_pkg and the top level
module resource_lock_table_with_generations_tb;
	import rltg_pkg::*;

	localparam logic [MODE_W-1:0] MODE_UNDEF_A = 3'd6;
	localparam logic [MODE_W-1:0] MODE_UNDEF_B = 3'd7;
	localparam int MAX_LOGGED = 40;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic [MODE_W-1:0]     s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;

	int err_count = 0;
	int word_idx = 0;
	int hold_cycles = 0;
	bit tx_idle_en = 1'b1;
	bit rx_idle_en = 1'b1;

	// predicted slot table
	logic             tbl_active [NUM_SLOTS_DEF];
	logic             tbl_canc [NUM_SLOTS_DEF];
	logic             tbl_cflag [NUM_SLOTS_DEF];
	logic [GEN_W-1:0] tbl_gen [NUM_SLOTS_DEF];
	logic [TIME_W-1:0] tbl_start [NUM_SLOTS_DEF];
	logic [ACTOR_W-1:0] tbl_actor [NUM_SLOTS_DEF];

	result_t pending_answers[$];

	resource_lock_table_with_generations dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report_mismatch(input string msg);
		if (err_count < MAX_LOGGED) begin
			$display("mismatch: %s", msg);
		end
		err_count++;
	endtask

	task automatic diff_field(input int idx, input string name,
			input logic [GEN_W-1:0] got, input logic [GEN_W-1:0] want);
		if (got !== want) begin
			report_mismatch($sformatf("word %0d %s got %0h want %0h", idx, name, got, want));
		end
	endtask

	function automatic int busy_total();
		int n;
		n = 0;
		for (int i = 0; i < NUM_SLOTS_DEF; i++)
			if (tbl_active[i]) n++;
		return n;
	endfunction

	function automatic logic maint_busy();
		if (MAINT_SLOT_DEF >= NUM_SLOTS_DEF) return 1'b0;
		return tbl_active[MAINT_SLOT_DEF];
	endfunction

	function automatic result_t lock_table_step(input item_t w);
		result_t res;
		logic [GEN_W-1:0] ng;
		logic in_range;
		logic is_maint;
		int r;
		int n;
		res = '0;
		r = int'(w.resource);
		in_range = r < NUM_SLOTS_DEF;
		is_maint = r == MAINT_SLOT_DEF;
		case (w.mode)
			MODE_BEGIN: begin
				if (in_range && w.actor >= 1 && w.actor <= ACTOR_MAX_DEF &&
						!(!is_maint && maint_busy()) &&
						!(is_maint && busy_total() > 0) && !tbl_active[r]) begin
					ng = tbl_gen[r] + GEN_W'(1);
					if (ng == '0) ng = GEN_W'(1);
					tbl_active[r] = 1'b1;
					tbl_canc[r] = w.cancellable;
					tbl_cflag[r] = 1'b0;
					tbl_gen[r] = ng;
					tbl_start[r] = w.start_time_ms;
					tbl_actor[r] = w.actor;
					res.ok = 1'b1;
					res.out_generation = ng;
				end
			end
			MODE_REQ_CANCEL: begin
				if (in_range && w.generation != '0 && tbl_active[r] && tbl_canc[r] &&
						tbl_gen[r] == w.generation) begin
					tbl_cflag[r] = 1'b1;
					res.ok = 1'b1;
				end
			end
			MODE_QRY_CANCEL: begin
				if (!in_range || w.generation == '0)
					res.ok = 1'b1;
				else
					res.ok = !tbl_active[r] || tbl_gen[r] != w.generation || tbl_cflag[r];
			end
			MODE_FINISH: begin
				if (in_range && w.generation != '0 && tbl_active[r] &&
						tbl_gen[r] == w.generation) begin
					tbl_active[r] = 1'b0;
					tbl_canc[r] = 1'b0;
					tbl_cflag[r] = 1'b0;
					tbl_start[r] = '0;
					tbl_actor[r] = '0;
					res.ok = 1'b1;
				end
			end
			MODE_MANUAL_OK: begin
				res.ok = in_range && !tbl_active[r] && (is_maint || !maint_busy());
			end
			MODE_READ: begin
				if (in_range) begin
					res.ok = 1'b1;
					res.out_generation = tbl_gen[r];
					res.slot_is_active = tbl_active[r];
					res.slot_is_cancellable = tbl_canc[r];
					res.slot_cancel_flag = tbl_cflag[r];
					res.slot_start_ms = tbl_start[r];
					res.slot_actor = tbl_actor[r];
				end
			end
			default: begin
			end
		endcase
		n = busy_total();
		res.active_total = (n > 15) ? {TOT_W{1'b1}} : n[TOT_W-1:0];
		return res;
	endfunction

	function automatic item_t make_word(input logic [MODE_W-1:0] mode,
			input int res, input int actor,
			input int canc, input logic [TIME_W-1:0] t, input logic [GEN_W-1:0] g);
		item_t w;
		w.mode = mode;
		w.resource = RES_W'(res);
		w.actor = ACTOR_W'(actor);
		w.cancellable = canc[0];
		w.start_time_ms = t;
		w.generation = g;
		return w;
	endfunction

	task automatic send_word(input item_t w);
		int gap;
		if (tx_idle_en && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 15);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= w.mode;
		s_tdata <= {w.generation, w.start_time_ms, w.cancellable, w.actor, w.resource};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		pending_answers.push_back(lock_table_step(w));
	endtask

	task automatic wait_drained();
		int spin;
		spin = 0;
		s_tvalid <= 1'b0;
		while (pending_answers.size() > 0 && spin < 20000) begin
			@(posedge clk);
			spin++;
		end
		foreach (pending_answers[i])
			report_mismatch($sformatf("expected word %0d of %0d never arrived",
				i, pending_answers.size()));
		pending_answers.delete();
		repeat (10) @(posedge clk);
	endtask

	task automatic send_random_op();
		item_t w;
		int pick;
		int busy_q[$];
		int r;
		pick = $urandom_range(0, 99);
		if (pick < 30) w.mode = MODE_BEGIN;
		else if (pick < 45) w.mode = MODE_REQ_CANCEL;
		else if (pick < 55) w.mode = MODE_QRY_CANCEL;
		else if (pick < 75) w.mode = MODE_FINISH;
		else if (pick < 83) w.mode = MODE_MANUAL_OK;
		else if (pick < 95) w.mode = MODE_READ;
		else w.mode = $urandom_range(0, 1) ? MODE_UNDEF_A : MODE_UNDEF_B;

		for (int i = 0; i < NUM_SLOTS_DEF; i++)
			if (tbl_active[i]) busy_q.push_back(i);
		if ((w.mode == MODE_REQ_CANCEL || w.mode == MODE_QRY_CANCEL ||
				w.mode == MODE_FINISH) && busy_q.size() > 0 && $urandom_range(0, 9) < 7)
			w.resource = RES_W'(busy_q[$urandom_range(0, busy_q.size() - 1)]);
		else if ($urandom_range(0, 9) == 0)
			w.resource = RES_W'($urandom_range(0, 15));
		else
			w.resource = RES_W'($urandom_range(0, NUM_SLOTS_DEF - 1));

		w.actor = ($urandom_range(0, 6) == 0) ? ACTOR_W'($urandom_range(0, 7)) :
			ACTOR_W'($urandom_range(1, ACTOR_MAX_DEF));
		w.cancellable = 1'($urandom_range(0, 1));
		w.start_time_ms = $urandom;

		// mostly the live token, sometimes the next one, a zero or a random one
		r = int'(w.resource);
		pick = $urandom_range(0, 19);
		if (r >= NUM_SLOTS_DEF || pick >= 16) w.generation = $urandom;
		else if (pick == 15) w.generation = '0;
		else if (pick == 14) w.generation = tbl_gen[r] + GEN_W'(1);
		else w.generation = tbl_gen[r];
		send_word(w);
	endtask

	task automatic test_directed_cases();
		send_word(make_word(MODE_READ, 0, 0, 0, 0, 0));
		send_word(make_word(MODE_READ, 15, 7, 1, '1, '1));
		send_word(make_word(MODE_BEGIN, 0, 1, 1, 32'hFFFF_FFFF, 0));
		send_word(make_word(MODE_BEGIN, 0, 2, 0, 0, 0));
		send_word(make_word(MODE_BEGIN, 1, 0, 0, 0, 0));
		send_word(make_word(MODE_BEGIN, 1, 7, 0, 0, 0));
		send_word(make_word(MODE_BEGIN, 1, ACTOR_MAX_DEF, 0, 32'h1234_5678, '1));
		// maintenance refused while other slots are busy
		send_word(make_word(MODE_BEGIN, MAINT_SLOT_DEF, 1, 1, 0, 0));
		send_word(make_word(MODE_REQ_CANCEL, 0, 0, 0, 0, 0));
		send_word(make_word(MODE_REQ_CANCEL, 0, 0, 0, 0, 2));
		send_word(make_word(MODE_REQ_CANCEL, 1, 0, 0, 0, 1));
		send_word(make_word(MODE_QRY_CANCEL, 0, 0, 0, 0, 1));
		send_word(make_word(MODE_REQ_CANCEL, 0, 0, 0, 0, 1));
		send_word(make_word(MODE_QRY_CANCEL, 0, 0, 0, 0, 1));
		send_word(make_word(MODE_QRY_CANCEL, 12, 0, 0, 0, 1));
		send_word(make_word(MODE_QRY_CANCEL, 1, 0, 0, 0, 0));
		send_word(make_word(MODE_MANUAL_OK, 2, 0, 0, 0, 0));
		send_word(make_word(MODE_MANUAL_OK, 9, 0, 0, 0, 0));
		send_word(make_word(MODE_READ, 0, 0, 0, 0, 0));
		send_word(make_word(MODE_FINISH, 0, 0, 0, 0, 0));
		send_word(make_word(MODE_FINISH, 0, 0, 0, 0, 1));
		send_word(make_word(MODE_FINISH, 1, 0, 0, 0, 1));
		// maintenance alone, then blocks everyone else
		send_word(make_word(MODE_BEGIN, MAINT_SLOT_DEF, 2, 0, 32'h8000_0001, 0));
		send_word(make_word(MODE_BEGIN, 2, 1, 1, 0, 0));
		send_word(make_word(MODE_MANUAL_OK, 2, 0, 0, 0, 0));
		send_word(make_word(MODE_FINISH, MAINT_SLOT_DEF, 0, 0, 0, 1));
		send_word(make_word(MODE_UNDEF_A, 15, 7, 1, '1, '1));
		send_word(make_word(MODE_UNDEF_B, 0, 0, 0, 0, 0));
		// finished slot keeps its generation
		send_word(make_word(MODE_READ, 0, 0, 0, 0, 0));
	endtask

	task automatic test_random_sessions(input int count);
		repeat (count) send_random_op();
	endtask

	task automatic test_maintenance_windows(input int rounds);
		repeat (rounds) begin
			for (int r = 0; r < NUM_SLOTS_DEF; r++)
				if (tbl_active[r]) send_word(make_word(MODE_FINISH, r, 0, 0, $urandom, tbl_gen[r]));
			send_word(make_word(MODE_BEGIN, MAINT_SLOT_DEF, $urandom_range(1, ACTOR_MAX_DEF),
				$urandom_range(0, 1), $urandom, $urandom));
			repeat ($urandom_range(2, 6)) send_random_op();
			if (tbl_active[MAINT_SLOT_DEF]) begin
				send_word(make_word(MODE_REQ_CANCEL, MAINT_SLOT_DEF, 0, 0, 0,
					tbl_gen[MAINT_SLOT_DEF]));
				send_word(make_word(MODE_QRY_CANCEL, MAINT_SLOT_DEF, 0, 0, 0,
					tbl_gen[MAINT_SLOT_DEF]));
				send_word(make_word(MODE_FINISH, MAINT_SLOT_DEF, 0, 0, 0,
					tbl_gen[MAINT_SLOT_DEF]));
			end
		end
	endtask

	task automatic test_output_stall();
		tx_idle_en = 1'b0;
		hold_cycles = 300;
		repeat (60) send_random_op();
		tx_idle_en = 1'b1;
		wait_drained();
	endtask

	task automatic test_unthrottled(input int count);
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		repeat (count) send_random_op();
	endtask

	// receiver ready: long hold when asked, else random stall bursts
	initial begin
		int burst;
		burst = 0;
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				hold_cycles--;
				m_tready <= 1'b0;
			end else if (burst > 0) begin
				burst--;
				m_tready <= 1'b0;
			end else if (rx_idle_en && $urandom_range(0, 4) == 0) begin
				burst = $urandom_range(1, 15) - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : watch_results
		result_t got;
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.ok = m_tdata[0];
			got.out_generation = m_tdata[32:1];
			got.slot_is_active = m_tdata[33];
			got.slot_is_cancellable = m_tdata[34];
			got.slot_cancel_flag = m_tdata[35];
			got.slot_start_ms = m_tdata[67:36];
			got.slot_actor = m_tdata[70:68];
			got.active_total = m_tdata[74:71];
			if (pending_answers.size() == 0) begin
				report_mismatch($sformatf("word %0d arrived with nothing expected", word_idx));
			end else begin
				want = pending_answers.pop_front();
				diff_field(word_idx, "ok", GEN_W'(got.ok), GEN_W'(want.ok));
				diff_field(word_idx, "out_generation", got.out_generation, want.out_generation);
				diff_field(word_idx, "slot_is_active", GEN_W'(got.slot_is_active),
					GEN_W'(want.slot_is_active));
				diff_field(word_idx, "slot_is_cancellable", GEN_W'(got.slot_is_cancellable),
					GEN_W'(want.slot_is_cancellable));
				diff_field(word_idx, "slot_cancel_flag", GEN_W'(got.slot_cancel_flag),
					GEN_W'(want.slot_cancel_flag));
				diff_field(word_idx, "slot_start_ms", got.slot_start_ms, want.slot_start_ms);
				diff_field(word_idx, "slot_actor", GEN_W'(got.slot_actor),
					GEN_W'(want.slot_actor));
				diff_field(word_idx, "active_total", GEN_W'(got.active_total),
					GEN_W'(want.active_total));
			end
			word_idx++;
		end
	end

	initial begin
		#5000000;
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		for (int i = 0; i < NUM_SLOTS_DEF; i++) begin
			tbl_active[i] = 1'b0;
			tbl_canc[i] = 1'b0;
			tbl_cflag[i] = 1'b0;
			tbl_gen[i] = '0;
			tbl_start[i] = '0;
			tbl_actor[i] = '0;
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		test_directed_cases();
		test_random_sessions(1250);
		test_maintenance_windows(15);
		test_output_stall();
		test_unthrottled(400);
		wait_drained();

		if (err_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+sv
sv/rltg_pkg.sv
sv/rltg_ctrl.sv
sv/rltg_dp.sv
sv/resource_lock_table_with_generations.sv
tb/sv/resource_lock_table_with_generations_tb.sv
